/* src/hdf_pkg.sv */
`default_nettype none
package hdf_pkg;

   localparam int TEXT_MAX_LEN   = 4;
   localparam int TEXT_REG_CHARS = 4;
   localparam int TEXT_LEN_CLAMP = (TEXT_MAX_LEN < TEXT_REG_CHARS) ? TEXT_MAX_LEN : TEXT_REG_CHARS;
   localparam int LEN_W          = 3;
   localparam int CHAR_IDX_W     = $clog2(TEXT_REG_CHARS);
   localparam int LINE_W         = 16;
   localparam int GROUP_W        = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int NUM_SEGS       = 6;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
   localparam logic [LINE_W-1:0] LINE_SAT = '1;

   typedef enum logic [1:0] {
      CMD_DATA    = 2'd0,
      CMD_FINISH  = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_GROUP_LEN   = 3'd0,
      CSR_LINE_LEN    = 3'd1,
      CSR_LINE_FLAGS  = 3'd2,
      CSR_PREFIX      = 3'd3,
      CSR_SUFFIX      = 3'd4,
      CSR_SEPARATOR   = 3'd5,
      CSR_TEXT_LENGTHS = 3'd6
   } csr_index_type;

   // Text segments of one item, in output order
   typedef enum logic [2:0] {
      SEG_SUFFIX   = 3'd0,
      SEG_POST_SEP = 3'd1,
      SEG_NEWLINE  = 3'd2,
      SEG_LEAD_SEP = 3'd3,
      SEG_PREFIX   = 3'd4,
      SEG_HEX      = 3'd5
   } seg_type;

   typedef logic [TEXT_REG_CHARS-1:0][7:0] text_type;

   typedef struct packed {
      logic [GROUP_W-1:0] group_len_max;
      logic [LINE_W-1:0]  line_len_max;
      logic [1:0]         line_flags;
      text_type           prefix_text;
      text_type           suffix_text;
      text_type           separator_text;
      logic [8:0]         text_lengths;
   } cfg_type;

   typedef struct packed {
      logic [NUM_SEGS-1:0] segs;
      logic [7:0]          data_byte;
   } entry_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] field);
      logic [LEN_W-1:0] lim;
      lim = LEN_W'(TEXT_LEN_CLAMP);
      return (field > lim) ? lim : field;
   endfunction

endpackage
`default_nettype wire

/* src/hdf_req_if.sv */
`default_nettype none
interface hdf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;

   modport source(output valid, command, data_byte, input ready);
   modport sink(input valid, command, data_byte, output ready);
endinterface
`default_nettype wire

/* src/hdf_rsp_if.sv */
`default_nettype none
interface hdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source(output valid, out_char, last, input ready);
   modport sink(input valid, out_char, last, output ready);
endinterface
`default_nettype wire

/* src/hdf_front.sv */
`default_nettype none
module hdf_front (
   input  wire logic            clock,
   input  wire logic            reset,
   hdf_req_if.sink              req,
   input  wire hdf_pkg::cfg_type cfg,
   input  wire logic            q_full,
   output logic                 q_push,
   output hdf_pkg::entry_type   q_entry
);
   import hdf_pkg::*;

   logic [GROUP_W-1:0] group_count_ff, group_count_in;
   logic [LINE_W-1:0]  line_count_ff, line_count_in;

   logic               accept;
   logic [LEN_W-1:0]   plen, slen, seplen, slen_if, post_len, pre_len;
   logic [GROUP_W-1:0] gmax;
   logic               pre, post, sfx, start, wrap, lc1_nz;
   logic [9:0]         need_const;
   logic [17:0]        need;
   logic [4:0]         nowrap_small, wrap_small;
   logic [16:0]        nowrap_sum;
   logic [LINE_W-1:0]  lc_data;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   assign plen   = clamp_len(cfg.text_lengths[2:0]);
   assign slen   = clamp_len(cfg.text_lengths[5:3]);
   assign seplen = clamp_len(cfg.text_lengths[8:6]);
   assign pre    = cfg.line_flags[0];
   assign post   = cfg.line_flags[1];
   assign gmax   = (cfg.group_len_max == '0) ? GROUP_W'(1) : cfg.group_len_max;
   assign post_len = post ? seplen : '0;
   assign pre_len  = pre ? seplen : '0;

   // Fixed part of the width check for a new group
   assign need_const = 10'(plen) + {1'b0, gmax, 1'b0} + 10'(slen) + 10'(post_len);

   assign sfx     = group_count_ff >= gmax;
   assign start   = sfx || (group_count_ff == '0);
   assign slen_if = sfx ? slen : '0;
   assign lc1_nz  = (line_count_ff != '0) || (slen_if != '0);

   assign need = 18'(line_count_ff) + 18'(slen_if) + 18'(need_const);
   assign wrap = start && (cfg.line_len_max != '0) && (need > 18'(cfg.line_len_max));

   // Line length both ways, then pick: no dependency on the wrap compare
   assign nowrap_small = start ? (5'((lc1_nz || pre) ? seplen : '0) + 5'(plen) + 5'd2) : 5'd2;
   assign nowrap_sum   = 17'(line_count_ff) + 17'(slen_if) + 17'(nowrap_small);
   assign wrap_small   = 5'(pre_len) + 5'(plen) + 5'd2;
   assign lc_data = wrap ? LINE_W'(wrap_small)
                         : ((nowrap_sum > 17'(LINE_SAT)) ? LINE_SAT : nowrap_sum[LINE_W-1:0]);

   always_comb begin
      group_count_in    = group_count_ff;
      line_count_in     = line_count_ff;
      q_push            = 1'b0;
      q_entry.segs      = '0;
      q_entry.data_byte = req.data_byte;
      if (accept) begin
         case (req.command)
            CMD_DATA: begin
               q_push                  = 1'b1;
               q_entry.segs[SEG_SUFFIX]   = sfx;
               q_entry.segs[SEG_POST_SEP] = wrap && post;
               q_entry.segs[SEG_NEWLINE]  = wrap;
               q_entry.segs[SEG_LEAD_SEP] = start && (wrap ? pre : (lc1_nz || pre));
               q_entry.segs[SEG_PREFIX]   = start;
               q_entry.segs[SEG_HEX]      = 1'b1;
               group_count_in = start ? GROUP_W'(1) : group_count_ff + GROUP_W'(1);
               line_count_in  = lc_data;
            end
            CMD_FINISH: begin
               q_push                  = 1'b1;
               q_entry.segs[SEG_SUFFIX]   = 1'b1;
               q_entry.segs[SEG_POST_SEP] = post;
               q_entry.segs[SEG_NEWLINE]  = 1'b1;
               group_count_in = '0;
               line_count_in  = '0;
            end
            CMD_RESTART: begin
               group_count_in = '0;
               line_count_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_count_ff <= '0;
         line_count_ff  <= '0;
      end else begin
         group_count_ff <= group_count_in;
         line_count_ff  <= line_count_in;
      end
   end

   a_data_opens_group: assert property (@(posedge clock) disable iff (reset)
      (accept && req.command == CMD_DATA) |=> (group_count_ff != '0 && line_count_ff >= 2))
      else $error("group or line count wrong after a data beat");

endmodule
`default_nettype wire

/* src/hdf_queue.sv */
`default_nettype none
module hdf_queue #(
   parameter int DEPTH = hdf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire hdf_pkg::entry_type push_entry,
   output logic                   full,
   input  wire logic              pop,
   output hdf_pkg::entry_type     head,
   output logic                   empty
);
   import hdf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule
`default_nettype wire

/* src/hdf_back.sv */
`default_nettype none
module hdf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hdf_pkg::cfg_type  cfg,
   input  wire hdf_pkg::entry_type head,
   input  wire logic              q_empty,
   output logic                   q_pop,
   hdf_rsp_if.source              rsp
);
   import hdf_pkg::*;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h61 + 8'(v) - 8'd10);
   endfunction

   logic                  busy_ff, busy_in;
   logic [NUM_SEGS-1:0]   mask_ff, mask_in;
   logic [CHAR_IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]      seg_len [NUM_SEGS];
   logic [NUM_SEGS-1:0]   nonempty, cur_mask, next_mask;
   seg_type               cur_seg;
   logic [7:0]            cur_byte, cur_char;
   logic                  have, step, seg_done, is_last;

   always_comb begin
      seg_len[SEG_SUFFIX]   = clamp_len(cfg.text_lengths[5:3]);
      seg_len[SEG_POST_SEP] = clamp_len(cfg.text_lengths[8:6]);
      seg_len[SEG_NEWLINE]  = LEN_W'(1);
      seg_len[SEG_LEAD_SEP] = clamp_len(cfg.text_lengths[8:6]);
      seg_len[SEG_PREFIX]   = clamp_len(cfg.text_lengths[2:0]);
      seg_len[SEG_HEX]      = LEN_W'(2);
      for (int i = 0; i < NUM_SEGS; i++) begin
         nonempty[i] = seg_len[i] != '0;
      end
   end

   // Start the next entry straight from the queue head, with no gap after the previous one
   assign cur_mask = busy_ff ? mask_ff : (head.segs & nonempty);
   assign cur_byte = busy_ff ? byte_ff : head.data_byte;

   always_comb begin
      cur_seg = SEG_SUFFIX;
      for (int i = NUM_SEGS - 1; i >= 0; i--) begin
         if (cur_mask[i]) begin
            cur_seg = seg_type'(3'(i));
         end
      end
   end

   always_comb begin
      case (cur_seg)
         SEG_SUFFIX:   cur_char = cfg.suffix_text[idx_ff];
         SEG_POST_SEP: cur_char = cfg.separator_text[idx_ff];
         SEG_NEWLINE:  cur_char = NEWLINE_CHAR;
         SEG_LEAD_SEP: cur_char = cfg.separator_text[idx_ff];
         SEG_PREFIX:   cur_char = cfg.prefix_text[idx_ff];
         SEG_HEX:      cur_char = hex_digit(idx_ff[0] ? cur_byte[3:0] : cur_byte[7:4]);
         default:      cur_char = NEWLINE_CHAR;
      endcase
   end

   assign seg_done = (LEN_W'(idx_ff) + LEN_W'(1)) == seg_len[cur_seg];

   always_comb begin
      next_mask = cur_mask;
      if (seg_done) begin
         next_mask[cur_seg] = 1'b0;
      end
   end

   assign is_last = next_mask == '0;
   assign have    = busy_ff || !q_empty;
   assign step    = have && (!rsp_valid_ff || rsp.ready);
   assign q_pop   = step && !busy_ff;

   always_comb begin
      busy_in      = busy_ff;
      mask_in      = mask_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         busy_in      = !is_last;
         mask_in      = next_mask;
         idx_in       = seg_done ? '0 : idx_ff + CHAR_IDX_W'(1);
         byte_in      = cur_byte;
         rsp_valid_in = 1'b1;
         rsp_char_in  = cur_char;
         rsp_last_in  = is_last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         mask_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         mask_ff      <= mask_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_char = rsp_char_ff;
   assign rsp.last     = rsp_last_ff;

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (mask_ff != '0))
      else $error("item in progress with no segments left");

   a_busy_not_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_valid_ff) |-> !rsp_last_ff)
      else $error("last beat sent while item still in progress");

endmodule
`default_nettype wire

/* src/hex_dump_formatter_core.sv */
`default_nettype none
// Hex dump text formatter.
// req: one beat per command. CMD_DATA encodes data_byte as two lowercase hex
//   digits, with group suffix, separators, newline and prefix around it as the
//   group and line counters call for. CMD_FINISH closes the group and line.
//   CMD_RESTART clears the counters and sends nothing; command 3 is dropped.
// rsp: one ASCII character per beat; last marks the final character of a
//   request. A data or finish request yields 1 to 19 characters.
// csr: write csr_wdata to register csr_index when csr_write_en is high. Write
//   only while no request is in flight.
// Flow: the front end classifies a request in the cycle it is accepted and
//   queues a segment plan; the first character reaches rsp through the plan
//   queue and the output register. While rsp.ready is high the back end sends
//   one character per cycle (a data byte inside a group makes 2), and it
//   moves straight to the next queued plan with no gap.
// Stall: with rsp.ready low the output register holds, the plan queue
//   (QUEUE_DEPTH entries) fills, then req.ready drops.
// Reset: registers go to their defaults (group length 1, rest zero), counters
//   clear, queue and output register empty.
module hex_dump_formatter_core #(
   parameter int QUEUE_DEPTH = hdf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hdf_req_if.sink          req,
   hdf_rsp_if.source        rsp,
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import hdf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type push_entry, head;
   logic      q_push, q_pop, q_full, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GROUP_LEN:    cfg_in.group_len_max  = csr_wdata[GROUP_W-1:0];
            CSR_LINE_LEN:     cfg_in.line_len_max   = csr_wdata[LINE_W-1:0];
            CSR_LINE_FLAGS:   cfg_in.line_flags     = csr_wdata[1:0];
            CSR_PREFIX:       cfg_in.prefix_text    = csr_wdata;
            CSR_SUFFIX:       cfg_in.suffix_text    = csr_wdata;
            CSR_SEPARATOR:    cfg_in.separator_text = csr_wdata;
            CSR_TEXT_LENGTHS: cfg_in.text_lengths   = csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{group_len_max: GROUP_W'(1), default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hdf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .cfg     (cfg_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   hdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head),
      .empty      (q_empty)
   );

   hdf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule
`default_nettype wire

/* sim/hex_dump_formatter_core_tb.sv */
`timescale 1ns / 100ps
module hex_dump_formatter_core_tb;
   import hdf_pkg::*;

   localparam int CLK_HALF       = 6;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 150;
   localparam int CFG_SPAN       = 15;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic [7:0] ZERO_CHAR    = 8'h30;
   localparam logic [7:0] LOWER_A_CHAR = 8'h61;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   hdf_req_if req_if();
   hdf_rsp_if rsp_if();

   hex_dump_formatter_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // Formatter state as the hardware should hold it
   cfg_type            fmt_cfg;
   logic [GROUP_W-1:0] group_fill;
   logic [LINE_W-1:0]  line_chars;
   logic [7:0]         item_chars[$];
   char_beat_type      expected_chars[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   logic hold_pending     = 1'b0;
   logic hold_done;
   int mismatch_count     = 0;
   int quiet_cycles       = 0;

   function automatic int unsigned text_len_of(int unsigned slot);
      int unsigned n;
      n = fmt_cfg.text_lengths[3*slot +: 3];
      return (n > TEXT_LEN_CLAMP) ? TEXT_LEN_CLAMP : n;
   endfunction

   function automatic void emit_text(text_type txt, int unsigned n);
      for (int unsigned i = 0; i < n; i++) item_chars.push_back(txt[i]);
   endfunction

   function automatic void add_line_chars(int unsigned k);
      int unsigned v;
      v = line_chars + k;
      line_chars = (v > LINE_SAT) ? LINE_SAT : LINE_W'(v);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      return (nib < 4'd10) ? ZERO_CHAR + 8'(nib) : LOWER_A_CHAR + 8'(nib) - 8'd10;
   endfunction

   // Work out the characters one accepted command produces and queue them
   function automatic void predict_text(logic [1:0] cmd, logic [7:0] data_in);
      int unsigned   plen, slen, seplen, gmax, need;
      logic          pre_sep, post_sep;
      char_beat_type beat;
      plen     = text_len_of(0);
      slen     = text_len_of(1);
      seplen   = text_len_of(2);
      pre_sep  = fmt_cfg.line_flags[0];
      post_sep = fmt_cfg.line_flags[1];
      gmax     = (fmt_cfg.group_len_max == '0) ? 1 : fmt_cfg.group_len_max;
      item_chars.delete();
      case (cmd)
         CMD_RESTART: begin
            group_fill = '0;
            line_chars = '0;
         end
         CMD_FINISH: begin
            group_fill = '0;
            emit_text(fmt_cfg.suffix_text, slen);
            if (post_sep) emit_text(fmt_cfg.separator_text, seplen);
            item_chars.push_back(NEWLINE_CHAR);
            line_chars = '0;
         end
         CMD_DATA: begin
            if (group_fill >= gmax) begin
               group_fill = '0;
               emit_text(fmt_cfg.suffix_text, slen);
               add_line_chars(slen);
            end
            if (group_fill == '0) begin
               need = line_chars + plen + 2 * gmax + slen + (post_sep ? seplen : 0);
               if (fmt_cfg.line_len_max != '0 && need > fmt_cfg.line_len_max) begin
                  if (post_sep) emit_text(fmt_cfg.separator_text, seplen);
                  item_chars.push_back(NEWLINE_CHAR);
                  line_chars = '0;
               end else if (line_chars != '0) begin
                  emit_text(fmt_cfg.separator_text, seplen);
                  add_line_chars(seplen);
               end
               if (pre_sep && line_chars == '0) begin
                  emit_text(fmt_cfg.separator_text, seplen);
                  add_line_chars(seplen);
               end
               emit_text(fmt_cfg.prefix_text, plen);
               add_line_chars(plen);
            end
            item_chars.push_back(hex_char(data_in[7:4]));
            item_chars.push_back(hex_char(data_in[3:0]));
            add_line_chars(2);
            group_fill = group_fill + 8'd1;
         end
         default: ;
      endcase
      foreach (item_chars[i]) begin
         beat.ch   = item_chars[i];
         beat.last = (i == item_chars.size() - 1);
         expected_chars.push_back(beat);
      end
   endfunction

   function automatic cfg_type random_format();
      cfg_type c;
      case ($urandom_range(9))
         0:       c.group_len_max = '0;
         1:       c.group_len_max = 8'd255;
         default: c.group_len_max = 8'($urandom_range(1, 6));
      endcase
      case ($urandom_range(9))
         0, 1, 2: c.line_len_max = '0;
         3:       c.line_len_max = 16'hffff;
         4:       c.line_len_max = 16'd1;
         default: c.line_len_max = 16'($urandom_range(8, 64));
      endcase
      c.line_flags     = 2'($urandom_range(3));
      c.prefix_text    = $urandom;
      c.suffix_text    = $urandom;
      c.separator_text = $urandom;
      c.text_lengths   = 9'($urandom_range(511));
      return c;
   endfunction

   task automatic send_item(logic [1:0] cmd, logic [7:0] data_in);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.command   = cmd;
      req_if.data_byte = data_in;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_text(cmd, data_in);
   endtask

   task automatic send_random_item();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 82)      send_item(CMD_DATA, 8'($urandom));
      else if (roll < 90) send_item(CMD_FINISH, 8'($urandom));
      else if (roll < 95) send_item(CMD_RESTART, 8'($urandom));
      else                send_item(CMD_UNUSED, 8'($urandom));
   endtask

   // Drop valid, let every expected beat arrive, then let the queue settle
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
   endtask

   task automatic load_format(cfg_type c);
      wait_idle();
      write_reg(CSR_GROUP_LEN, 32'(c.group_len_max));
      write_reg(CSR_LINE_LEN, 32'(c.line_len_max));
      write_reg(CSR_LINE_FLAGS, 32'(c.line_flags));
      write_reg(CSR_PREFIX, 32'(c.prefix_text));
      write_reg(CSR_SUFFIX, 32'(c.suffix_text));
      write_reg(CSR_SEPARATOR, 32'(c.separator_text));
      write_reg(CSR_TEXT_LENGTHS, 32'(c.text_lengths));
      @(negedge clock);
      csr_write_en = 1'b0;
      fmt_cfg = c;
   endtask

   task automatic test_reset_defaults();
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_DATA, 8'hff);
      send_item(CMD_DATA, 8'h5a);
      send_item(CMD_DATA, 8'ha5);
      send_item(CMD_FINISH, 8'h00);
      send_item(CMD_UNUSED, 8'h3c);
      send_item(CMD_RESTART, 8'hc3);
      send_item(CMD_DATA, 8'h09);
   endtask

   // Prefix "0x", suffix ";", separator " | " plus a NUL, its length field
   // above the clamp; both line flags on and a narrow line to force wraps
   task automatic test_text_segments();
      cfg_type c;
      c.group_len_max  = 8'd2;
      c.line_len_max   = 16'd20;
      c.line_flags     = 2'b11;
      c.prefix_text    = 32'h0000_7830;
      c.suffix_text    = 32'h0000_003b;
      c.separator_text = 32'h0020_7c20;
      c.text_lengths   = {3'd7, 3'd1, 3'd2};
      load_format(c);
      for (int i = 0; i < 10; i++) send_item(CMD_DATA, 8'(i * 8'h1d));
      send_item(CMD_FINISH, 8'h00);
      send_item(CMD_FINISH, 8'h00);
      send_item(CMD_DATA, 8'h7e);
      send_item(CMD_RESTART, 8'h00);
      send_item(CMD_DATA, 8'h81);
   endtask

   task automatic test_group_extremes();
      cfg_type c;
      sender_idle_pct    = 9;
      receiver_stall_pct = 9;
      c = random_format();
      c.group_len_max = '0;
      c.line_len_max  = 16'd12;
      load_format(c);
      repeat (6) send_item(CMD_DATA, 8'($urandom));
      c = random_format();
      c.group_len_max = 8'd255;
      c.line_len_max  = 16'd600;
      c.line_flags    = 2'b10;
      load_format(c);
      repeat (20) send_item(CMD_DATA, 8'($urandom));
      send_item(CMD_FINISH, 8'h00);
   endtask

   // Hold rsp low long enough for the plan queue to fill and stall req
   task automatic test_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      load_format(random_format());
      @(negedge clock);
      hold_pending = 1'b1;
      repeat (30) send_item(CMD_DATA, 8'($urandom));
      send_item(CMD_FINISH, 8'h00);
   endtask

   task automatic run_random_traffic(int n, int snd_idle, int rcv_stall);
      sender_idle_pct    = snd_idle;
      receiver_stall_pct = rcv_stall;
      for (int i = 0; i < n; i++) begin
         if (i % CFG_SPAN == 0) load_format(random_format());
         send_random_item();
      end
   endtask

   // Long unwrapped line with every text segment at full length
   task automatic test_long_line();
      cfg_type c;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      c = random_format();
      c.group_len_max = 8'd1;
      c.line_len_max  = '0;
      c.line_flags    = 2'b01;
      c.text_lengths  = {3'd4, 3'd4, 3'd4};
      load_format(c);
      repeat (20) send_item(CMD_DATA, 8'($urandom));
      send_item(CMD_FINISH, 8'h00);
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.command   = CMD_DATA;
      req_if.data_byte = '0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_GROUP_LEN;
      csr_wdata        = '0;
      fmt_cfg          = '0;
      fmt_cfg.group_len_max = 8'd1;
      group_fill       = '0;
      line_chars       = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_text_segments();
      test_group_extremes();
      test_backpressure();
      run_random_traffic(20, 0, 0);
      run_random_traffic(20, 50, 0);
      run_random_traffic(20, 0, 50);
      run_random_traffic(20, 9, 9);
      test_long_line();
      wait_idle();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left    = 0;
      hold_done    = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   function automatic void note_mismatch(string what, logic [7:0] exp_val, logic [7:0] act_val);
      $display("%0t: %s expected %02h actual %02h", $time, what, exp_val, act_val);
      mismatch_count++;
   endfunction

   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_chars.size() == 0) begin
            note_mismatch("unexpected beat, out_char", 8'hxx, rsp_if.out_char);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_if.out_char !== want.ch)
               note_mismatch("out_char", want.ch, rsp_if.out_char);
            if (rsp_if.last !== want.last)
               note_mismatch("last", 8'(want.last), 8'(rsp_if.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
